FILE: design/pid_pkg.sv
// ============================================================================
// pid_pkg - shared constants of the PID controller step
// Fixed field widths, register indexes and blend constants.
// ============================================================================
`default_nettype none

package pid_pkg;

    // Field widths fixed by the interface
    localparam int IN_W       = 16;
    localparam int ERR_W      = 17;
    localparam int DERR_W     = 18;
    localparam int GAIN_W     = 16;
    localparam int COEF_W     = 17;
    localparam int LIM_W      = 31;
    localparam int DRIVE_W    = 40;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 31;

    // Shared multiplier: signed 18 x signed 18
    localparam int MUL_W   = 18;
    localparam int PROD_W  = 2 * MUL_W;

    // Blend works on 16-bit digits of the difference
    localparam int CHUNK_W = 16;

    localparam logic [COEF_W-1:0] COEF_ONE   = 17'h10000;
    localparam int                ROUND_HALF = 32768;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_COEF    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT_ON = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND      = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MAX     = 4'd7;

endpackage

`default_nettype wire

FILE: design/pid_controller_step.sv
// ============================================================================
// pid_controller_step - positional PID controller, one sample per transfer
// Error, P/I/D terms, saturating integral with optional clamp, optional
// output blend with the previous drive, dead band and output clamp.
// ============================================================================
//
//  channel   direction  handshake            payload
//  --------  ---------  -------------------  -----------------------------
//  in        sink       in_valid / in_stall  setpoint, measure
//  out       source     out_valid/out_stall  drive
//  cfg       sink       cfg_write            cfg_index, cfg_data
//
//  The one shared 18x18 multiplier and its sequencer step through a sample
//  in order; in_stall holds off the next transfer until the sequence is back
//  in idle. With the filter on, the blend walks the difference 16 bits per
//  clock, in N = ceil((ACC_WIDTH+1)/16) digits (3 at ACC_WIDTH = 40).
//  Reset clears the integral, previous error, previous drive and all
//  configuration registers. A result held by out_stall does not block the
//  next sample's transfer; only the final step waits for the output register.
//
`default_nettype none

module pid_controller_step #(
    parameter int ACC_WIDTH = 40
) (
    input  wire                                        clk,
    input  wire                                        rst_n,
    // input samples
    input  wire                                        in_valid,
    output logic                                       in_stall,
    input  wire  signed [pid_pkg::IN_W-1:0]            setpoint,
    input  wire  signed [pid_pkg::IN_W-1:0]            measure,
    // results
    output logic                                       out_valid,
    input  wire                                        out_stall,
    output logic signed [pid_pkg::DRIVE_W-1:0]         drive,
    // configuration
    input  wire                                        cfg_write,
    input  wire         [pid_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire         [pid_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int SW     = ACC_WIDTH + 2;
    localparam int NCHUNK = (ACC_WIDTH + 1 + pid_pkg::CHUNK_W - 1) / pid_pkg::CHUNK_W;
    localparam int QW     = NCHUNK * pid_pkg::CHUNK_W;
    localparam int KW     = $clog2(NCHUNK);
    localparam int CW     = pid_pkg::PROD_W - pid_pkg::CHUNK_W;
    localparam int EXT_W  = (ACC_WIDTH > pid_pkg::DRIVE_W) ? ACC_WIDTH : pid_pkg::DRIVE_W;

    localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_P,
        S_I,
        S_CLAMP,
        S_D,
        S_SUM,
        S_DIFF,
        S_BLEND,
        S_MIX,
        S_DEAD,
        S_LIMIT,
        S_OUT
    } state_t;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                                 state_reg, state_next;
    logic                                   out_valid_reg, out_valid_next;
    logic signed [pid_pkg::DRIVE_W-1:0]     drive_reg, drive_next;

    logic signed [pid_pkg::GAIN_W-1:0]      prop_gain_reg, prop_gain_next;
    logic signed [pid_pkg::GAIN_W-1:0]      integ_gain_reg, integ_gain_next;
    logic signed [pid_pkg::GAIN_W-1:0]      deriv_gain_reg, deriv_gain_next;
    logic        [pid_pkg::COEF_W-1:0]      filter_coef_reg, filter_coef_next;
    logic        [pid_pkg::LIM_W-1:0]       integ_limit_reg, integ_limit_next;
    logic                                   integ_limit_on_reg, integ_limit_on_next;
    logic        [pid_pkg::LIM_W-1:0]       dead_band_reg, dead_band_next;
    logic        [pid_pkg::LIM_W-1:0]       output_max_reg, output_max_next;

    logic signed [ACC_WIDTH-1:0]            integ_reg, integ_next;
    logic signed [pid_pkg::ERR_W-1:0]       prev_err_reg, prev_err_next;
    logic signed [ACC_WIDTH-1:0]            prev_drive_reg, prev_drive_next;

    logic signed [pid_pkg::ERR_W-1:0]       err_reg, err_next;
    logic signed [pid_pkg::DERR_W-1:0]      derr_reg, derr_next;
    logic signed [ACC_WIDTH-1:0]            y_reg, y_next;
    logic        [QW-1:0]                   d_reg, d_next;
    logic        [QW-1:0]                   q_reg, q_next;
    logic signed [CW-1:0]                   carry_reg, carry_next;
    logic        [KW-1:0]                   k_reg, k_next;

    // ------------------------------------------------------------------
    // Shared multiplier
    // ------------------------------------------------------------------
    logic signed [pid_pkg::MUL_W-1:0]       mul_a, mul_b;
    logic signed [pid_pkg::PROD_W-1:0]      mul_p;
    logic                                   last_chunk;

    assign last_chunk = (k_reg == KW'(NCHUNK - 1));

    always_comb
    begin
        case (state_reg)
            S_I:
            begin
                mul_a = pid_pkg::MUL_W'(integ_gain_reg);
                mul_b = pid_pkg::MUL_W'(err_reg);
            end
            S_D:
            begin
                mul_a = pid_pkg::MUL_W'(deriv_gain_reg);
                mul_b = derr_reg;
            end
            S_BLEND:
            begin
                // low digits are unsigned, the top digit carries the sign
                if (last_chunk)
                    mul_a = pid_pkg::MUL_W'($signed(d_reg[pid_pkg::CHUNK_W-1:0]));
                else
                    mul_a = $signed({2'b00, d_reg[pid_pkg::CHUNK_W-1:0]});
                mul_b = $signed({1'b0, filter_coef_reg});
            end
            default:
            begin
                mul_a = pid_pkg::MUL_W'(prop_gain_reg);
                mul_b = pid_pkg::MUL_W'(err_reg);
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // ------------------------------------------------------------------
    // Shared saturating adder
    // ------------------------------------------------------------------
    logic signed [SW-1:0]                   add_a, add_b, add_sum;
    logic signed [ACC_WIDTH-1:0]            add_sat;
    logic        [SW-ACC_WIDTH:0]           add_hi;

    always_comb
    begin
        case (state_reg)
            S_I:
            begin
                add_a = SW'(integ_reg);
                add_b = SW'(mul_p);
            end
            S_D:
            begin
                add_a = SW'(y_reg);
                add_b = SW'(mul_p);
            end
            S_MIX:
            begin
                add_a = SW'(prev_drive_reg);
                add_b = SW'($signed(q_reg[ACC_WIDTH:0]));
            end
            default:
            begin
                add_a = SW'(y_reg);
                add_b = SW'(integ_reg);
            end
        endcase
    end

    assign add_sum = add_a + add_b;
    assign add_hi  = add_sum[SW-1:ACC_WIDTH-1];

    always_comb
    begin
        if (add_hi == '0 || add_hi == '1)
            add_sat = add_sum[ACC_WIDTH-1:0];
        else if (add_sum[SW-1])
            add_sat = ACC_MIN;
        else
            add_sat = ACC_MAX;
    end

    // ------------------------------------------------------------------
    // Bounds, blend digit step and output view
    // ------------------------------------------------------------------
    logic signed [ACC_WIDTH-1:0]            lim_int, lim_db, lim_out;
    logic signed [pid_pkg::PROD_W-1:0]      blend_t;
    logic signed [EXT_W-1:0]                y_ext;

    assign lim_int = $signed({{(ACC_WIDTH-pid_pkg::LIM_W){1'b0}}, integ_limit_reg});
    assign lim_db  = $signed({{(ACC_WIDTH-pid_pkg::LIM_W){1'b0}}, dead_band_reg});
    assign lim_out = $signed({{(ACC_WIDTH-pid_pkg::LIM_W){1'b0}}, output_max_reg});
    assign blend_t = pid_pkg::PROD_W'(carry_reg) + mul_p;
    assign y_ext   = EXT_W'(y_reg);

    // ------------------------------------------------------------------
    // Sequencer and datapath next values
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next          = state_reg;
        out_valid_next      = out_valid_reg && out_stall;
        drive_next          = drive_reg;
        prop_gain_next      = prop_gain_reg;
        integ_gain_next     = integ_gain_reg;
        deriv_gain_next     = deriv_gain_reg;
        filter_coef_next    = filter_coef_reg;
        integ_limit_next    = integ_limit_reg;
        integ_limit_on_next = integ_limit_on_reg;
        dead_band_next      = dead_band_reg;
        output_max_next     = output_max_reg;
        integ_next          = integ_reg;
        prev_err_next       = prev_err_reg;
        prev_drive_next     = prev_drive_reg;
        err_next            = err_reg;
        derr_next           = derr_reg;
        y_next              = y_reg;
        d_next              = d_reg;
        q_next              = q_reg;
        carry_next          = carry_reg;
        k_next              = k_reg;

        // register writes
        if (cfg_write)
        begin
            unique case (cfg_index)
                pid_pkg::REG_PROP_GAIN:
                    prop_gain_next = $signed(cfg_data[pid_pkg::GAIN_W-1:0]);
                pid_pkg::REG_INTEG_GAIN:
                    integ_gain_next = $signed(cfg_data[pid_pkg::GAIN_W-1:0]);
                pid_pkg::REG_DERIV_GAIN:
                    deriv_gain_next = $signed(cfg_data[pid_pkg::GAIN_W-1:0]);
                pid_pkg::REG_FILTER_COEF:
                    if (cfg_data[pid_pkg::COEF_W-1:0] > pid_pkg::COEF_ONE)
                        filter_coef_next = pid_pkg::COEF_ONE;
                    else
                        filter_coef_next = cfg_data[pid_pkg::COEF_W-1:0];
                pid_pkg::REG_INTEG_LIMIT:
                    integ_limit_next = cfg_data;
                pid_pkg::REG_INTEG_LIMIT_ON:
                    integ_limit_on_next = cfg_data[0];
                pid_pkg::REG_DEAD_BAND:
                    dead_band_next = cfg_data;
                pid_pkg::REG_OUTPUT_MAX:
                    output_max_next = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                // take the sample and form the error
                if (in_valid)
                begin
                    err_next   = pid_pkg::ERR_W'(setpoint) - pid_pkg::ERR_W'(measure);
                    state_next = S_P;
                end
            end
            S_P:
            begin
                y_next     = ACC_WIDTH'(mul_p);
                derr_next  = pid_pkg::DERR_W'(err_reg) - pid_pkg::DERR_W'(prev_err_reg);
                state_next = S_I;
            end
            S_I:
            begin
                integ_next = add_sat;
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                // optional integral bound
                if (integ_limit_on_reg && integ_limit_reg != '0)
                begin
                    if (integ_reg > lim_int)
                        integ_next = lim_int;
                    else if (integ_reg < -lim_int)
                        integ_next = -lim_int;
                end
                state_next = S_D;
            end
            S_D:
            begin
                y_next        = add_sat;
                prev_err_next = err_reg;
                state_next    = S_SUM;
            end
            S_SUM:
            begin
                y_next = add_sat;
                if (filter_coef_reg != '0)
                    state_next = S_DIFF;
                else
                    state_next = S_DEAD;
            end
            S_DIFF:
            begin
                // blend as prev + round((y - prev) * c / 2^16)
                d_next     = QW'(SW'(y_reg) - SW'(prev_drive_reg));
                carry_next = CW'(pid_pkg::ROUND_HALF);
                k_next     = '0;
                state_next = S_BLEND;
            end
            S_BLEND:
            begin
                // one 16-bit digit per clock, low digit first
                carry_next = blend_t[pid_pkg::PROD_W-1:pid_pkg::CHUNK_W];
                d_next     = d_reg >> pid_pkg::CHUNK_W;
                if (k_reg != '0)
                    q_next = {blend_t[2*pid_pkg::CHUNK_W-1:0],
                              q_reg[QW-pid_pkg::CHUNK_W-1:pid_pkg::CHUNK_W]};
                k_next = k_reg + 1'b1;
                if (last_chunk)
                    state_next = S_MIX;
            end
            S_MIX:
            begin
                y_next     = add_sat;
                state_next = S_DEAD;
            end
            S_DEAD:
            begin
                if (dead_band_reg != '0)
                begin
                    if (y_reg > 0 && y_reg < lim_db)
                        y_next = '0;
                    else if (y_reg < 0 && y_reg > -lim_db)
                        y_next = '0;
                end
                state_next = S_LIMIT;
            end
            S_LIMIT:
            begin
                if (output_max_reg != '0)
                begin
                    if (y_reg > lim_out)
                        y_next = lim_out;
                    else if (y_reg < -lim_out)
                        y_next = -lim_out;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // hand over once the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    drive_next      = y_ext[pid_pkg::DRIVE_W-1:0];
                    out_valid_next  = 1'b1;
                    prev_drive_next = y_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            out_valid_reg      <= 1'b0;
            drive_reg          <= '0;
            prop_gain_reg      <= '0;
            integ_gain_reg     <= '0;
            deriv_gain_reg     <= '0;
            filter_coef_reg    <= '0;
            integ_limit_reg    <= '0;
            integ_limit_on_reg <= 1'b0;
            dead_band_reg      <= '0;
            output_max_reg     <= '0;
            integ_reg          <= '0;
            prev_err_reg       <= '0;
            prev_drive_reg     <= '0;
            err_reg            <= '0;
            derr_reg           <= '0;
            y_reg              <= '0;
            d_reg              <= '0;
            q_reg              <= '0;
            carry_reg          <= '0;
            k_reg              <= '0;
        end
        else
        begin
            state_reg          <= state_next;
            out_valid_reg      <= out_valid_next;
            drive_reg          <= drive_next;
            prop_gain_reg      <= prop_gain_next;
            integ_gain_reg     <= integ_gain_next;
            deriv_gain_reg     <= deriv_gain_next;
            filter_coef_reg    <= filter_coef_next;
            integ_limit_reg    <= integ_limit_next;
            integ_limit_on_reg <= integ_limit_on_next;
            dead_band_reg      <= dead_band_next;
            output_max_reg     <= output_max_next;
            integ_reg          <= integ_next;
            prev_err_reg       <= prev_err_next;
            prev_drive_reg     <= prev_drive_next;
            err_reg            <= err_next;
            derr_reg           <= derr_next;
            y_reg              <= y_next;
            d_reg              <= d_next;
            q_reg              <= q_next;
            carry_reg          <= carry_next;
            k_reg              <= k_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_start_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_P))
        else $error("sample transfer did not start the sequence");

    a_result_from_final_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_OUT))
        else $error("result raised outside the final step");

    a_digit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BLEND) |-> (k_reg <= KW'(NCHUNK - 1)))
        else $error("blend digit counter overran");

endmodule

`default_nettype wire
